[rtl/cpuls_pkg.sv]
// ----------------------------------------------------------------------------
// cpuls_pkg
// Shared types and constants of the load-group cpu core: memory geometry,
// action and register codes, opcodes, sequencer states and the memory request.
// ----------------------------------------------------------------------------
package cpuls_pkg;

    // memory geometry
    localparam int MEM_AW    = 16;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int BYTE_W    = 8;

    // stream word widths
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 96;

    // what an input word asks for
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_EXEC  = 2'd2
    } action_t;

    // register codes as used in opcode fields
    localparam logic [2:0] REG_B   = 3'd0;
    localparam logic [2:0] REG_C   = 3'd1;
    localparam logic [2:0] REG_D   = 3'd2;
    localparam logic [2:0] REG_E   = 3'd3;
    localparam logic [2:0] REG_H   = 3'd4;
    localparam logic [2:0] REG_L   = 3'd5;
    localparam logic [2:0] REG_HLM = 3'd6;
    localparam logic [2:0] REG_A   = 3'd7;

    // opcodes handled outside the register-to-register block
    localparam logic [7:0] OP_LD_BC_D16  = 8'h01;
    localparam logic [7:0] OP_LD_DE_D16  = 8'h11;
    localparam logic [7:0] OP_LD_HL_D16  = 8'h21;
    localparam logic [7:0] OP_LD_SP_D16  = 8'h31;
    localparam logic [7:0] OP_LD_BCI_A   = 8'h02;
    localparam logic [7:0] OP_LD_DEI_A   = 8'h12;
    localparam logic [7:0] OP_LD_A_BCI   = 8'h0A;
    localparam logic [7:0] OP_LD_A_DEI   = 8'h1A;
    localparam logic [7:0] OP_LD_A16_SP  = 8'h08;
    localparam logic [7:0] OP_LD_HLI_A   = 8'h22;
    localparam logic [7:0] OP_LD_HLD_A   = 8'h32;
    localparam logic [7:0] OP_LD_A_HLI   = 8'h2A;
    localparam logic [7:0] OP_LD_A_HLD   = 8'h3A;
    localparam logic [7:0] OP_LDH_C_A    = 8'hE2;
    localparam logic [7:0] OP_LDH_A_C    = 8'hF2;
    localparam logic [7:0] OP_LD_A16_A   = 8'hEA;
    localparam logic [7:0] OP_LD_A_A16   = 8'hFA;
    localparam logic [7:0] OP_HALT       = 8'h76;

    // high page base for the (0xFF00+C) forms
    localparam logic [7:0] HIGH_PAGE = 8'hFF;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDWAIT,
        ST_OPC,
        ST_IMM1,
        ST_IMM2,
        ST_WR2,
        ST_LOAD,
        ST_RESULT
    } state_t;

    // one access on the single memory port
    typedef struct packed {
        logic              we;
        logic              re;
        logic [MEM_AW-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } mem_req_t;

endpackage

[rtl/cpu_load_store_executor_core.sv]
// ----------------------------------------------------------------------------
// cpu_load_store_executor_core
// 8-bit cpu core for the load instruction group with an internal 64 KiB
// byte memory; memory write, memory read or one instruction per word.
// ----------------------------------------------------------------------------
// After reset the core sweeps the whole memory to zero, one byte per cycle,
// so s_tready stays low until the sweep is done. Then each input word is
// handled on its own through one memory port with registered read data.
// An instruction runs through opcode fetch, up to two immediate bytes, up
// to two data accesses, then the result hand-off. The next word is taken
// as soon as the result has moved to the output register, even if that
// result is still waiting on m_tready. Opcodes outside the load group are
// one-byte no-ops.
module cpu_load_store_executor_core import cpuls_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // address[15:0], data[23:16]
    input  logic [S_USER_W-1:0] s_tuser,   // action[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // pc_out[15:0], sp_out[31:16],
                                           // a_out[39:32], b_out[47:40],
                                           // c_out[55:48], d_out[63:56],
                                           // e_out[71:64], h_out[79:72],
                                           // l_out[87:80], read_data[95:88]
);

    state_t            state_reg, state_next;
    logic [MEM_AW-1:0] clr_reg, clr_next;
    logic [15:0]       pc_reg, pc_next, sp_reg, sp_next;
    logic [7:0]        a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [7:0]        d_reg, d_next, e_reg, e_next, h_reg, h_next, l_reg, l_next;
    logic [7:0]        op_reg, op_next, lo_reg, lo_next, rd_reg, rd_next;
    logic [2:0]        dst_reg, dst_next;
    logic [MEM_AW-1:0] addr_reg, addr_next;
    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    mem_req_t          mem_req;
    logic [7:0]        mem_rdata;

    action_t           s_action;
    logic [15:0]       s_address;
    logic [7:0]        s_data;

    logic [7:0]        op_cur;
    logic [2:0]        op_src, op_dst;
    logic              is_ldrr, is_ld_d8, is_d16, is_load_a;
    logic [7:0]        src_val;
    logic [15:0]       hl, bc, de, imm_word;
    logic              out_free, out_load;
    logic              wr_en;
    logic [2:0]        wr_code;
    logic [7:0]        wr_val;

    cpuls_ram u_ram (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // input word fields
    assign s_action  = action_t'(s_tuser);
    assign s_address = s_tdata[15:0];
    assign s_data    = s_tdata[23:16];

    // opcode decode, opcode comes straight from memory in the fetch state
    assign op_cur    = (state_reg == ST_OPC) ? mem_rdata : op_reg;
    assign op_src    = op_cur[2:0];
    assign op_dst    = op_cur[5:3];
    assign is_ldrr   = (op_cur[7:6] == 2'b01) && (op_cur != OP_HALT);
    assign is_ld_d8  = (op_cur[7:6] == 2'b00) && (op_cur[2:0] == REG_HLM);
    assign is_d16    = op_cur inside {OP_LD_BC_D16, OP_LD_DE_D16, OP_LD_HL_D16,
                                      OP_LD_SP_D16, OP_LD_A16_SP, OP_LD_A16_A,
                                      OP_LD_A_A16};
    assign is_load_a = op_cur inside {OP_LD_A_BCI, OP_LD_A_DEI, OP_LD_A_HLI,
                                      OP_LD_A_HLD, OP_LDH_A_C};

    assign hl       = {h_reg, l_reg};
    assign bc       = {b_reg, c_reg};
    assign de       = {d_reg, e_reg};
    assign imm_word = {mem_rdata, lo_reg};

    // source register of a register-to-register load
    always_comb begin
        case (op_src)
            REG_B:   src_val = b_reg;
            REG_C:   src_val = c_reg;
            REG_D:   src_val = d_reg;
            REG_E:   src_val = e_reg;
            REG_H:   src_val = h_reg;
            REG_L:   src_val = l_reg;
            REG_A:   src_val = a_reg;
            default: src_val = '0;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == '1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_action)
                        ACT_READ: state_next = ST_RDWAIT;
                        ACT_EXEC: state_next = ST_OPC;
                        default:  state_next = ST_RESULT;
                    endcase
                end
            end
            ST_RDWAIT: state_next = ST_RESULT;
            ST_OPC: begin
                if (is_d16 || is_ld_d8) begin
                    state_next = ST_IMM1;
                end else if ((is_ldrr && op_src == REG_HLM) || is_load_a) begin
                    state_next = ST_LOAD;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_IMM1: begin
                state_next = is_d16 ? ST_IMM2 : ST_RESULT;
            end
            ST_IMM2: begin
                case (op_reg)
                    OP_LD_A16_SP: state_next = ST_WR2;
                    OP_LD_A_A16:  state_next = ST_LOAD;
                    default:      state_next = ST_RESULT;
                endcase
            end
            ST_WR2:    state_next = ST_RESULT;
            ST_LOAD:   state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // memory access, register updates and hand-off per state
    always_comb begin
        clr_next  = clr_reg;
        pc_next   = pc_reg;
        sp_next   = sp_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        h_next    = h_reg;
        l_next    = l_reg;
        op_next   = op_reg;
        lo_next   = lo_reg;
        rd_next   = rd_reg;
        dst_next  = dst_reg;
        addr_next = addr_reg;
        mem_req   = '0;
        wr_en     = 1'b0;
        wr_code   = REG_A;
        wr_val    = '0;
        out_load  = 1'b0;
        s_tready  = (state_reg == ST_IDLE);

        case (state_reg)
            ST_CLEAR: begin
                mem_req.we   = 1'b1;
                mem_req.addr = clr_reg;
                clr_next     = clr_reg + MEM_AW'(1);
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    rd_next = '0;
                    case (s_action)
                        ACT_WRITE: begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = s_address;
                            mem_req.wdata = s_data;
                        end
                        ACT_READ: begin
                            mem_req.re   = 1'b1;
                            mem_req.addr = s_address;
                        end
                        ACT_EXEC: begin
                            mem_req.re   = 1'b1;
                            mem_req.addr = pc_reg;
                            pc_next      = pc_reg + 16'd1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RDWAIT: begin
                rd_next = mem_rdata;
            end
            ST_OPC: begin
                op_next = mem_rdata;
                if (is_d16 || is_ld_d8) begin
                    // first immediate byte
                    mem_req.re   = 1'b1;
                    mem_req.addr = pc_reg;
                    pc_next      = pc_reg + 16'd1;
                end else if (is_ldrr) begin
                    if (op_src == REG_HLM) begin
                        mem_req.re   = 1'b1;
                        mem_req.addr = hl;
                        dst_next     = op_dst;
                    end else if (op_dst == REG_HLM) begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = hl;
                        mem_req.wdata = src_val;
                    end else begin
                        wr_en   = 1'b1;
                        wr_code = op_dst;
                        wr_val  = src_val;
                    end
                end else begin
                    case (op_cur)
                        OP_LD_BCI_A: begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = bc;
                            mem_req.wdata = a_reg;
                        end
                        OP_LD_DEI_A: begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = de;
                            mem_req.wdata = a_reg;
                        end
                        OP_LD_HLI_A: begin
                            mem_req.we       = 1'b1;
                            mem_req.addr     = hl;
                            mem_req.wdata    = a_reg;
                            {h_next, l_next} = hl + 16'd1;
                        end
                        OP_LD_HLD_A: begin
                            mem_req.we       = 1'b1;
                            mem_req.addr     = hl;
                            mem_req.wdata    = a_reg;
                            {h_next, l_next} = hl - 16'd1;
                        end
                        OP_LDH_C_A: begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = {HIGH_PAGE, c_reg};
                            mem_req.wdata = a_reg;
                        end
                        OP_LD_A_BCI: begin
                            mem_req.re   = 1'b1;
                            mem_req.addr = bc;
                            dst_next     = REG_A;
                        end
                        OP_LD_A_DEI: begin
                            mem_req.re   = 1'b1;
                            mem_req.addr = de;
                            dst_next     = REG_A;
                        end
                        OP_LD_A_HLI: begin
                            mem_req.re       = 1'b1;
                            mem_req.addr     = hl;
                            dst_next         = REG_A;
                            {h_next, l_next} = hl + 16'd1;
                        end
                        OP_LD_A_HLD: begin
                            mem_req.re       = 1'b1;
                            mem_req.addr     = hl;
                            dst_next         = REG_A;
                            {h_next, l_next} = hl - 16'd1;
                        end
                        OP_LDH_A_C: begin
                            mem_req.re   = 1'b1;
                            mem_req.addr = {HIGH_PAGE, c_reg};
                            dst_next     = REG_A;
                        end
                        default: ;
                    endcase
                end
            end
            ST_IMM1: begin
                lo_next = mem_rdata;
                if (is_d16) begin
                    // high immediate byte
                    mem_req.re   = 1'b1;
                    mem_req.addr = pc_reg;
                    pc_next      = pc_reg + 16'd1;
                end else if (op_dst == REG_HLM) begin
                    mem_req.we    = 1'b1;
                    mem_req.addr  = hl;
                    mem_req.wdata = mem_rdata;
                end else begin
                    wr_en   = 1'b1;
                    wr_code = op_dst;
                    wr_val  = mem_rdata;
                end
            end
            ST_IMM2: begin
                case (op_reg)
                    OP_LD_BC_D16: {b_next, c_next} = imm_word;
                    OP_LD_DE_D16: {d_next, e_next} = imm_word;
                    OP_LD_HL_D16: {h_next, l_next} = imm_word;
                    OP_LD_SP_D16: sp_next = imm_word;
                    OP_LD_A16_SP: begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = imm_word;
                        mem_req.wdata = sp_reg[7:0];
                        addr_next     = imm_word + 16'd1;
                    end
                    OP_LD_A16_A: begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = imm_word;
                        mem_req.wdata = a_reg;
                    end
                    OP_LD_A_A16: begin
                        mem_req.re   = 1'b1;
                        mem_req.addr = imm_word;
                        dst_next     = REG_A;
                    end
                    default: ;
                endcase
            end
            ST_WR2: begin
                // high byte of sp, address wraps
                mem_req.we    = 1'b1;
                mem_req.addr  = addr_reg;
                mem_req.wdata = sp_reg[15:8];
            end
            ST_LOAD: begin
                wr_en   = 1'b1;
                wr_code = dst_reg;
                wr_val  = mem_rdata;
            end
            ST_RESULT: begin
                out_load = out_free;
            end
            default: ;
        endcase

        // register file write
        if (wr_en) begin
            case (wr_code)
                REG_B:   b_next = wr_val;
                REG_C:   c_next = wr_val;
                REG_D:   d_next = wr_val;
                REG_E:   e_next = wr_val;
                REG_H:   h_next = wr_val;
                REG_L:   l_next = wr_val;
                REG_A:   a_next = wr_val;
                default: ;
            endcase
        end
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            sp_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            d_reg     <= '0;
            e_reg     <= '0;
            h_reg     <= '0;
            l_reg     <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
            e_reg     <= e_next;
            h_reg     <= h_next;
            l_reg     <= l_next;
        end
    end

    // per-word working registers
    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        lo_reg   <= lo_next;
        rd_reg   <= rd_next;
        dst_reg  <= dst_next;
        addr_reg <= addr_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {rd_reg, l_reg, h_reg, e_reg, d_reg, c_reg, b_reg,
                            a_reg, sp_reg, pc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/cpuls_ram.sv]
// ----------------------------------------------------------------------------
// cpuls_ram
// 64 KiB single-port byte memory, read data registered.
// ----------------------------------------------------------------------------
module cpuls_ram import cpuls_pkg::*; (
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] ram [MEM_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            ram[req.addr] <= req.wdata;
        end
    end

    // registered read, held when no read is issued
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= ram[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[bench/tb_cpu_load_store_executor_core.sv]
// ----------------------------------------------------------------------------
// tb_cpu_load_store_executor_core
// Self-checking bench for the load-group cpu core. A short table of directed
// words is followed by random programs that are written into memory byte by
// byte and executed. A shadow copy of the registers and the memory predicts
// each result word not given by value in the table; every result is checked
// field by field, the random part in four phases of input idles and stalls.
// ----------------------------------------------------------------------------
module tb_cpu_load_store_executor_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cpuls_pkg::*;

    // action code with no meaning to the core
    localparam logic [1:0] ACT_NONE = 2'd3;

    // opcodes not named in the package
    localparam logic [7:0] OP_LD_A_D8  = 8'h3E;
    localparam logic [7:0] OP_NOT_LOAD = 8'hD3;

    // load opcodes outside the register-to-register block
    localparam int         N_LOAD_OPS = 17;
    localparam logic [N_LOAD_OPS*8-1:0] LOAD_OPS = {
        OP_LD_BC_D16, OP_LD_DE_D16, OP_LD_HL_D16, OP_LD_SP_D16,
        OP_LD_BCI_A, OP_LD_DEI_A, OP_LD_A_BCI, OP_LD_A_DEI,
        OP_LD_A16_SP, OP_LD_HLI_A, OP_LD_HLD_A, OP_LD_A_HLI, OP_LD_A_HLD,
        OP_LDH_C_A, OP_LDH_A_C, OP_LD_A16_A, OP_LD_A_A16
    };

    // small window where data and pointers tend to meet
    localparam logic [15:0] DATA_WIN = 16'hC000;

    localparam int DIR_ROWS     = 25;
    localparam int RAND_PER_PH  = 206;
    localparam int WATCHDOG_LIM = 200000;
    localparam int DRAIN_CYCLES = 20;

    localparam bit         CHK     = 1'b1;
    localparam bit         NOCHK   = 1'b0;
    localparam logic [63:0] NO_VIEW = '0;

    // one result word, read_data in the top bits down to pc_out at the bottom
    typedef struct packed {
        logic [7:0]  rd;
        logic [7:0]  l;
        logic [7:0]  h;
        logic [7:0]  e;
        logic [7:0]  d;
        logic [7:0]  c;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [15:0] sp;
        logic [15:0] pc;
    } cpu_view_t;

    // directed row: stimulus and, where checked by value, pc, sp, a, hl, read byte
    typedef struct packed {
        logic        chk;
        logic [1:0]  act;
        logic [15:0] addr;
        logic [7:0]  dat;
        logic [15:0] pc;
        logic [15:0] sp;
        logic [7:0]  a;
        logic [15:0] hl;
        logic [7:0]  rd;
    } dir_row_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // address[15:0], data[23:16]
    logic [S_USER_W-1:0] s_tuser  = '0;   // action[1:0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // pc_out[15:0], sp_out[31:16],
                                          // a_out[39:32], b_out[47:40],
                                          // c_out[55:48], d_out[63:56],
                                          // e_out[71:64], h_out[79:72],
                                          // l_out[87:80], read_data[95:88]

    // shadow state of the core
    logic [15:0] pc_q;
    logic [15:0] sp_q;
    logic [7:0]  rf [8];
    logic [7:0]  mem_img [65536];

    cpu_view_t pending_views [$];
    int        idle_pct    = 0;
    int        stall_pct   = 0;
    int        words_sent  = 0;
    int        mismatches  = 0;

    cpu_load_store_executor_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // shadow register and memory access
    function automatic logic [7:0] rd_reg(input logic [2:0] code);
        return (code == REG_HLM) ? mem_img[{rf[REG_H], rf[REG_L]}] : rf[code];
    endfunction

    function automatic void wr_reg(input logic [2:0] code, input logic [7:0] val);
        if (code == REG_HLM) begin
            mem_img[{rf[REG_H], rf[REG_L]}] = val;
        end else begin
            rf[code] = val;
        end
    endfunction

    function automatic logic [7:0] fetch_byte();
        logic [7:0] val;
        val  = mem_img[pc_q];
        pc_q = pc_q + 16'd1;
        return val;
    endfunction

    // 16-bit immediate, low byte first
    function automatic logic [15:0] fetch_word();
        logic [7:0] lo, hi;
        lo = fetch_byte();
        hi = fetch_byte();
        return {hi, lo};
    endfunction

    // advance the shadow core by one word and return the result it gives
    function automatic cpu_view_t cpu_step(input logic [1:0] act, input logic [15:0] addr,
                                           input logic [7:0] dat);
        cpu_view_t   v;
        logic [7:0]  op;
        logic [15:0] w, hl;
        v = '0;
        case (act)
            ACT_WRITE: mem_img[addr] = dat;
            ACT_READ:  v.rd = mem_img[addr];
            ACT_EXEC: begin
                op = fetch_byte();
                hl = {rf[REG_H], rf[REG_L]};
                if (op[7:6] == 2'b01) begin
                    // register to register; halt is a plain no-op here
                    if (op != OP_HALT) wr_reg(op[5:3], rd_reg(op[2:0]));
                end else if (op[7:6] == 2'b00 && op[2:0] == REG_HLM) begin
                    // 8-bit immediate sits where the (hl) source code would be
                    wr_reg(op[5:3], fetch_byte());
                end else begin
                    case (op)
                        OP_LD_BC_D16: {rf[REG_B], rf[REG_C]} = fetch_word();
                        OP_LD_DE_D16: {rf[REG_D], rf[REG_E]} = fetch_word();
                        OP_LD_HL_D16: {rf[REG_H], rf[REG_L]} = fetch_word();
                        OP_LD_SP_D16: sp_q = fetch_word();
                        OP_LD_BCI_A:  mem_img[{rf[REG_B], rf[REG_C]}] = rf[REG_A];
                        OP_LD_DEI_A:  mem_img[{rf[REG_D], rf[REG_E]}] = rf[REG_A];
                        OP_LD_A_BCI:  rf[REG_A] = mem_img[{rf[REG_B], rf[REG_C]}];
                        OP_LD_A_DEI:  rf[REG_A] = mem_img[{rf[REG_D], rf[REG_E]}];
                        OP_LD_A16_SP: begin
                            w = fetch_word();
                            mem_img[w] = sp_q[7:0];
                            w = w + 16'd1;
                            mem_img[w] = sp_q[15:8];
                        end
                        OP_LD_HLI_A: begin
                            mem_img[hl] = rf[REG_A];
                            {rf[REG_H], rf[REG_L]} = hl + 16'd1;
                        end
                        OP_LD_HLD_A: begin
                            mem_img[hl] = rf[REG_A];
                            {rf[REG_H], rf[REG_L]} = hl - 16'd1;
                        end
                        OP_LD_A_HLI: begin
                            rf[REG_A] = mem_img[hl];
                            {rf[REG_H], rf[REG_L]} = hl + 16'd1;
                        end
                        OP_LD_A_HLD: begin
                            rf[REG_A] = mem_img[hl];
                            {rf[REG_H], rf[REG_L]} = hl - 16'd1;
                        end
                        OP_LDH_C_A:  mem_img[{HIGH_PAGE, rf[REG_C]}] = rf[REG_A];
                        OP_LDH_A_C:  rf[REG_A] = mem_img[{HIGH_PAGE, rf[REG_C]}];
                        OP_LD_A16_A: begin
                            w = fetch_word();
                            mem_img[w] = rf[REG_A];
                        end
                        OP_LD_A_A16: rf[REG_A] = mem_img[fetch_word()];
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        v.pc = pc_q;
        v.sp = sp_q;
        v.a  = rf[REG_A];
        v.b  = rf[REG_B];
        v.c  = rf[REG_C];
        v.d  = rf[REG_D];
        v.e  = rf[REG_E];
        v.h  = rf[REG_H];
        v.l  = rf[REG_L];
        return v;
    endfunction

    // directed words, checked by value where the result is plain
    function automatic dir_row_t dir_row(input int idx);
        dir_row_t r;
        r = '0;
        case (idx)
            // fresh memory reads zero, unused action changes nothing
            0:  r = {CHK,   ACT_READ,  16'hFFFF, 8'h00, 16'h0000, 16'h0000, 8'h00,
                     16'h0000, 8'h00};
            1:  r = {CHK,   ACT_NONE,  16'hFFFF, 8'hFF, 16'h0000, 16'h0000, 8'h00,
                     16'h0000, 8'h00};
            // sp to all ones
            2:  r = {NOCHK, ACT_WRITE, 16'h0000, OP_LD_SP_D16, NO_VIEW};
            3:  r = {NOCHK, ACT_WRITE, 16'h0001, 8'hFF, NO_VIEW};
            4:  r = {NOCHK, ACT_WRITE, 16'h0002, 8'hFF, NO_VIEW};
            5:  r = {CHK,   ACT_EXEC,  16'h0000, 8'h00, 16'h0003, 16'hFFFF, 8'h00,
                     16'h0000, 8'h00};
            // a to all ones
            6:  r = {NOCHK, ACT_WRITE, 16'h0003, OP_LD_A_D8, NO_VIEW};
            7:  r = {NOCHK, ACT_WRITE, 16'h0004, 8'hFF, NO_VIEW};
            8:  r = {CHK,   ACT_EXEC,  16'hFFFF, 8'hFF, 16'h0005, 16'hFFFF, 8'hFF,
                     16'h0000, 8'h00};
            // store sp at the top byte, high byte wraps to address zero
            9:  r = {NOCHK, ACT_WRITE, 16'h0005, OP_LD_A16_SP, NO_VIEW};
            10: r = {NOCHK, ACT_WRITE, 16'h0006, 8'hFF, NO_VIEW};
            11: r = {NOCHK, ACT_WRITE, 16'h0007, 8'hFF, NO_VIEW};
            12: r = {CHK,   ACT_EXEC,  16'h0000, 8'h00, 16'h0008, 16'hFFFF, 8'hFF,
                     16'h0000, 8'h00};
            13: r = {CHK,   ACT_READ,  16'h0000, 8'h00, 16'h0008, 16'hFFFF, 8'hFF,
                     16'h0000, 8'hFF};
            // halt and an opcode outside the group skip one byte
            14: r = {NOCHK, ACT_WRITE, 16'h0008, OP_HALT, NO_VIEW};
            15: r = {CHK,   ACT_EXEC,  16'h0000, 8'h00, 16'h0009, 16'hFFFF, 8'hFF,
                     16'h0000, 8'h00};
            16: r = {NOCHK, ACT_WRITE, 16'h0009, OP_NOT_LOAD, NO_VIEW};
            17: r = {CHK,   ACT_EXEC,  16'h0000, 8'h00, 16'h000A, 16'hFFFF, 8'hFF,
                     16'h0000, 8'h00};
            // hl to the top, then store with post-increment wrapping to zero
            18: r = {NOCHK, ACT_WRITE, 16'h000A, OP_LD_HL_D16, NO_VIEW};
            19: r = {NOCHK, ACT_WRITE, 16'h000B, 8'hFF, NO_VIEW};
            20: r = {NOCHK, ACT_WRITE, 16'h000C, 8'hFF, NO_VIEW};
            21: r = {CHK,   ACT_EXEC,  16'h0000, 8'h00, 16'h000D, 16'hFFFF, 8'hFF,
                     16'hFFFF, 8'h00};
            22: r = {NOCHK, ACT_WRITE, 16'h000D, OP_LD_HLI_A, NO_VIEW};
            23: r = {CHK,   ACT_EXEC,  16'h0000, 8'h00, 16'h000E, 16'hFFFF, 8'hFF,
                     16'h0000, 8'h00};
            24: r = {CHK,   ACT_READ,  16'hFFFF, 8'h00, 16'h000E, 16'hFFFF, 8'hFF,
                     16'h0000, 8'hFF};
            default: ;
        endcase
        return r;
    endfunction

    // send one input word and queue the result it should give
    task automatic send_word(input logic [1:0] act, input logic [15:0] addr,
                             input logic [7:0] dat, input bit known, input cpu_view_t typed);
        cpu_view_t v;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {dat, addr};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        v = cpu_step(act, addr, dat);
        pending_views.push_back(known ? typed : v);
        words_sent++;
    endtask

    // addresses that tend to hit live data, pointers, the high page or the extremes
    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom);
            1:       return DATA_WIN | 16'($urandom_range(0, 31));
            2:       return {HIGH_PAGE, 8'($urandom)};
            3:       return {rf[REG_H], rf[REG_L]};
            4:       return {rf[REG_B], rf[REG_C]};
            5:       return {rf[REG_D], rf[REG_E]};
            // the instruction's own operand bytes
            6:       return pc_q + 16'd1;
            default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    function automatic logic [7:0] pick_opcode();
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'h40 + 8'($urandom_range(0, 63));
            4, 5:       return {2'b00, 3'($urandom_range(0, 7)), REG_HLM};
            6, 7, 8: begin
                k = $urandom_range(0, N_LOAD_OPS - 1);
                return LOAD_OPS[k*8 +: 8];
            end
            default:    return 8'($urandom);
        endcase
    endfunction

    // random programs written at pc and run, mixed with loose words
    task automatic run_random(input int n);
        int          target, roll, n_imm;
        logic [7:0]  op;
        logic [15:0] imm;
        target = words_sent + n;
        while (words_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                op  = pick_opcode();
                imm = pick_addr();
                case (op)
                    OP_LD_BC_D16, OP_LD_DE_D16, OP_LD_HL_D16, OP_LD_SP_D16,
                    OP_LD_A16_SP, OP_LD_A16_A, OP_LD_A_A16: n_imm = 2;
                    default: n_imm = (op[7:6] == 2'b00 && op[2:0] == REG_HLM) ? 1 : 0;
                endcase
                send_word(ACT_WRITE, pc_q, op, NOCHK, '0);
                if (n_imm == 1) send_word(ACT_WRITE, pc_q + 16'd1, 8'($urandom), NOCHK, '0);
                if (n_imm == 2) begin
                    send_word(ACT_WRITE, pc_q + 16'd1, imm[7:0], NOCHK, '0);
                    send_word(ACT_WRITE, pc_q + 16'd2, imm[15:8], NOCHK, '0);
                end
                send_word(ACT_EXEC, 16'($urandom), 8'($urandom), NOCHK, '0);
            end else if (roll < 85) begin
                send_word(ACT_WRITE, pick_addr(), 8'($urandom), NOCHK, '0);
            end else if (roll < 95) begin
                send_word(ACT_READ, pick_addr(), 8'($urandom), NOCHK, '0);
            end else if (roll < 97) begin
                send_word(ACT_NONE, 16'($urandom), 8'($urandom), NOCHK, '0);
            end else begin
                // run whatever bytes lie at pc
                send_word(ACT_EXEC, 16'($urandom), 8'($urandom), NOCHK, '0);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    // result checker, sampled mid-cycle
    always @(negedge aclk) begin : result_check
        cpu_view_t got, want;
        if (m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_views.size() == 0) begin
                $error("result word %h with nothing expected", m_tdata);
                mismatches++;
            end else begin
                want = pending_views.pop_front();
                check_field("pc_out", want.pc, got.pc);
                check_field("sp_out", want.sp, got.sp);
                check_field("a_out", want.a, got.a);
                check_field("b_out", want.b, got.b);
                check_field("c_out", want.c, got.c);
                check_field("d_out", want.d, got.d);
                check_field("e_out", want.e, got.e);
                check_field("h_out", want.h, got.h);
                check_field("l_out", want.l, got.l);
                check_field("read_data", want.rd, got.rd);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIM) begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("cpu_load_store_executor_core test failed");
        $finish;
    end

    // main sequence
    initial begin : stimulus
        dir_row_t  row;
        cpu_view_t typed;
        int        ph;
        int        ph_idle [4];
        int        ph_stall [4];
        ph_idle  = '{0, 83, 0, 6};
        ph_stall = '{0, 0, 83, 6};

        pc_q = '0;
        sp_q = '0;
        for (int i = 0; i < 8; i++) rf[i] = '0;
        for (int i = 0; i < 65536; i++) mem_img[i] = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            row      = dir_row(i);
            typed    = '0;
            typed.pc = row.pc;
            typed.sp = row.sp;
            typed.a  = row.a;
            typed.h  = row.hl[15:8];
            typed.l  = row.hl[7:0];
            typed.rd = row.rd;
            send_word(row.act, row.addr, row.dat, row.chk, typed);
        end

        for (ph = 0; ph < 4; ph++) begin
            idle_pct  = ph_idle[ph];
            stall_pct = ph_stall[ph];
            run_random(RAND_PER_PH);
        end

        // drain
        s_tvalid  <= 1'b0;
        stall_pct = 0;
        while (pending_views.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("cpu_load_store_executor_core test passed");
        end else begin
            $display("cpu_load_store_executor_core test failed");
        end
        $finish;
    end

endmodule

[cpu_load_store_executor_core.f]
rtl/cpuls_pkg.sv
rtl/cpuls_ram.sv
rtl/cpu_load_store_executor_core.sv
bench/tb_cpu_load_store_executor_core.sv
